[src/mwece_pkg.sv]
// ----------------------------------------------------------------------------
// mwece_pkg: shared constants and types for the Microwire EEPROM command executor
// Codes for commands, sequencer states and the kind of pending operation.
// ----------------------------------------------------------------------------
package mwece_pkg;

  localparam int unsigned StoreWordsDefault = 1024;

  // Widest address field: start bit at 15, two opcode bits, 13 address bits.
  localparam int unsigned FieldW = 13;
  localparam int unsigned WordW  = 16;

  localparam logic [WordW-1:0] ErasedWord = 16'hFFFF;

  // Opcodes
  localparam logic [1:0] OpExt   = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;
  localparam logic [1:0] OpErase = 2'd3;

  // Sub-commands of the extended opcode
  localparam logic [1:0] SubWrDis  = 2'd0;
  localparam logic [1:0] SubWrAll  = 2'd1;
  localparam logic [1:0] SubErAll  = 2'd2;
  localparam logic [1:0] SubWrEn   = 2'd3;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_REDUCE = 6'b000100,
    ST_EXEC   = 6'b001000,
    ST_FILL   = 6'b010000,
    ST_RESP   = 6'b100000
  } state_e;

  typedef enum logic [2:0] {
    K_PASS  = 3'd0,
    K_ZERO  = 3'd1,
    K_WRITE = 3'd2,
    K_READ  = 3'd3,
    K_ERASE = 3'd4,
    K_FILL  = 3'd5
  } kind_e;

endpackage

[src/microwire_eeprom_command_executor.sv]
// ----------------------------------------------------------------------------
// microwire_eeprom_command_executor
// Runs 93C46-style Microwire commands against an on-chip word store.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one transaction carries a command word (tdata[15:0]) and a
//   data word (tdata[31:16]). Master stream: one result per command, the
//   returned word in tdata[15:0] and the write-enable flag in tdata[16].
//   cfg_we_i/cfg_data_i write device_present; write it only while idle.
// Flow (one command at a time, set by the store's single write port and the
//   address reduction loop):
//   read/write/erase: RedSteps reduction steps, then execute, then response
//     (RedSteps = 3 at 1024 words); other single commands go straight to response,
//   write-all / erase-all: N = words filled, one per cycle, then response.
// Reset: the sequencer sweeps the whole store to FFFF, one word per cycle,
//   with s_axis_tready low; config writes still land.
// Stall: a finished result sits in the output register; the next command is
//   still taken and worked on, and waits at the end until the slot frees.
// ----------------------------------------------------------------------------
module microwire_eeprom_command_executor #(
  parameter int unsigned STORE_WORDS = mwece_pkg::StoreWordsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config: device_present
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] command_word, [31:16] data_in
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [15:0] data_out, [16] write_enabled, rest 0
);

  localparam int unsigned FieldW = mwece_pkg::FieldW;
  localparam int unsigned WordW  = mwece_pkg::WordW;
  localparam int unsigned AW     = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam logic [AW-1:0] LastAddr = AW'(STORE_WORDS - 1);
  localparam logic [FieldW-1:0] LastField = FieldW'(STORE_WORDS - 1);
  // Restoring reduction steps: shifts k with (STORE_WORDS << k) <= max field.
  localparam int unsigned RedRaw   = $clog2(((1 << FieldW) - 1) / STORE_WORDS + 1);
  localparam int unsigned RedSteps = (RedRaw < 1) ? 1 : RedRaw;
  localparam int unsigned KW       = (RedSteps > 1) ? $clog2(RedSteps) : 1;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  mwece_pkg::state_e state_q, state_d;
  mwece_pkg::kind_e  kind_q, kind_d;

  logic              present_q;
  logic              wen_q, wen_d;          // write-enable flag
  logic [FieldW-1:0] addr_q, addr_d;        // address field, reduced in place
  logic [KW-1:0]     red_k_q, red_k_d;
  logic [WordW-1:0]  data_q, data_d;
  logic [AW-1:0]     fill_addr_q, fill_addr_d;
  logic [AW-1:0]     fill_last_q, fill_last_d;
  logic [WordW-1:0]  fill_val_q, fill_val_d;

  logic              m_valid_q, m_valid_d;
  logic [WordW-1:0]  m_data_q, m_data_d;
  logic              m_wen_q, m_wen_d;

  // word store, one write and one read port, registered read
  logic [WordW-1:0]  mem_q [STORE_WORDS];
  logic [WordW-1:0]  rdata_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr;
  logic [WordW-1:0]  mem_wdata;

  // --------------------------------------------------------------------------
  // Command decode (on the incoming transaction)
  // --------------------------------------------------------------------------
  logic [WordW-1:0]  cmd, din;
  logic [3:0]        s_pos, sh2, sh4;
  logic [1:0]        op, sub;
  logic [WordW-1:0]  one_sh, amask16;
  logic [FieldW-1:0] amask, field, wa_last;
  logic              accept;

  assign cmd    = s_axis_tdata[15:0];
  assign din    = s_axis_tdata[31:16];
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s_pos = 4'd0;
    for (int i = 0; i < WordW; i++) begin
      if (cmd[i]) s_pos = 4'(i);
    end
  end

  assign sh2     = s_pos - 4'd2;
  assign sh4     = s_pos - 4'd4;
  assign op      = 2'(cmd >> sh2);
  assign sub     = 2'(cmd >> sh4);
  assign one_sh  = 16'd1 << sh2;
  assign amask16 = one_sh - 16'd1;
  assign amask   = amask16[FieldW-1:0];
  assign field   = cmd[FieldW-1:0] & amask;
  // write-all covers min(2^(s-2), STORE_WORDS) words
  assign wa_last = (amask < LastField) ? amask : LastField;

  // --------------------------------------------------------------------------
  // Reduction step: subtract STORE_WORDS << k when it fits
  // --------------------------------------------------------------------------
  logic [31:0] red_div;
  logic [31:0] addr_ext;
  assign red_div  = 32'(STORE_WORDS) << red_k_q;
  assign addr_ext = 32'(addr_q);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign s_axis_tready = (state_q == mwece_pkg::ST_IDLE);

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    wen_d       = wen_q;
    addr_d      = addr_q;
    red_k_d     = red_k_q;
    data_d      = data_q;
    fill_addr_d = fill_addr_q;
    fill_last_d = fill_last_q;
    fill_val_d  = fill_val_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_data_d    = m_data_q;
    m_wen_d     = m_wen_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = fill_addr_q;
    mem_wdata   = fill_val_q;

    unique case (state_q)
      mwece_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = mwece_pkg::ErasedWord;
        if (fill_addr_q == LastAddr) begin
          fill_addr_d = '0;
          state_d     = mwece_pkg::ST_IDLE;
        end else begin
          fill_addr_d = fill_addr_q + AW'(1);
        end
      end

      mwece_pkg::ST_IDLE: begin
        if (accept) begin
          data_d  = din;
          addr_d  = field;
          red_k_d = KW'(RedSteps - 1);
          state_d = mwece_pkg::ST_RESP;
          if (!present_q || cmd == '0) begin
            kind_d = mwece_pkg::K_PASS;
          end else if (s_pos < 4'd4) begin
            kind_d = mwece_pkg::K_ZERO;
            wen_d  = 1'b0;
          end else begin
            unique case (op)
              mwece_pkg::OpExt: begin
                kind_d = mwece_pkg::K_ZERO;
                unique case (sub)
                  mwece_pkg::SubWrDis: wen_d = 1'b0;
                  mwece_pkg::SubWrEn:  wen_d = 1'b1;
                  mwece_pkg::SubWrAll: begin
                    kind_d      = mwece_pkg::K_FILL;
                    fill_last_d = wa_last[AW-1:0];
                    fill_val_d  = din;
                    state_d     = mwece_pkg::ST_FILL;
                  end
                  mwece_pkg::SubErAll: begin
                    if (wen_q) begin
                      kind_d      = mwece_pkg::K_FILL;
                      fill_last_d = LastAddr;
                      fill_val_d  = mwece_pkg::ErasedWord;
                      state_d     = mwece_pkg::ST_FILL;
                    end
                  end
                  default: ;
                endcase
              end
              mwece_pkg::OpWrite: begin
                kind_d  = mwece_pkg::K_WRITE;
                state_d = mwece_pkg::ST_REDUCE;
              end
              mwece_pkg::OpRead: begin
                kind_d  = mwece_pkg::K_READ;
                state_d = mwece_pkg::ST_REDUCE;
              end
              mwece_pkg::OpErase: begin
                kind_d  = mwece_pkg::K_ERASE;
                state_d = mwece_pkg::ST_REDUCE;
              end
              default: ;
            endcase
          end
        end
      end

      mwece_pkg::ST_REDUCE: begin
        if (addr_ext >= red_div) addr_d = FieldW'(addr_ext - red_div);
        if (red_k_q == '0) begin
          state_d = mwece_pkg::ST_EXEC;
        end else begin
          red_k_d = red_k_q - KW'(1);
        end
      end

      mwece_pkg::ST_EXEC: begin
        mem_waddr = addr_q[AW-1:0];
        mem_wdata = (kind_q == mwece_pkg::K_WRITE) ? data_q : mwece_pkg::ErasedWord;
        mem_we    = wen_q && (kind_q == mwece_pkg::K_WRITE || kind_q == mwece_pkg::K_ERASE);
        mem_re    = (kind_q == mwece_pkg::K_READ);
        state_d   = mwece_pkg::ST_RESP;
      end

      mwece_pkg::ST_FILL: begin
        mem_we = 1'b1;
        if (fill_addr_q == fill_last_q) begin
          fill_addr_d = '0;
          state_d     = mwece_pkg::ST_RESP;
        end else begin
          fill_addr_d = fill_addr_q + AW'(1);
        end
      end

      mwece_pkg::ST_RESP: begin
        // wait for a free output slot
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_wen_d   = wen_q;
          case (kind_q)
            mwece_pkg::K_PASS: m_data_d = data_q;
            mwece_pkg::K_READ: m_data_d = rdata_q;
            default:           m_data_d = '0;
          endcase
          state_d = mwece_pkg::ST_IDLE;
        end
      end

      default: state_d = mwece_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mwece_pkg::ST_CLEAR;
      kind_q      <= mwece_pkg::K_PASS;
      present_q   <= 1'b1;
      wen_q       <= 1'b0;
      red_k_q     <= '0;
      fill_addr_q <= '0;
      fill_last_q <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      if (cfg_we_i) present_q <= cfg_data_i;
      wen_q       <= wen_d;
      red_k_q     <= red_k_d;
      fill_addr_q <= fill_addr_d;
      fill_last_q <= fill_last_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    data_q     <= data_d;
    fill_val_q <= fill_val_d;
    m_data_q   <= m_data_d;
    m_wen_q    <= m_wen_d;
  end

  // word store
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[addr_q[AW-1:0]];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, m_wen_q, m_data_q};

endmodule

[verif/microwire_eeprom_command_executor_tb.sv]
// ----------------------------------------------------------------------------
// microwire_eeprom_command_executor_tb: self-checking bench for the command executor
// Drives command/data pairs on the slave stream and tracks the word store and
// the write-enable flag in a local model. Every result on the master stream is
// compared field by field against the oldest expected reply. A short directed
// table runs first, then random traffic under several backpressure profiles,
// with device_present toggled between phases.
// ----------------------------------------------------------------------------
module microwire_eeprom_command_executor_tb;

  localparam int unsigned StoreWords = mwece_pkg::StoreWordsDefault;
  // Safety net only: far above the slowest legal run, reset sweep included.
  localparam int unsigned TimeoutUnits = 4_000_000;
  // Receiver hold-off used to back the block up into its input.
  localparam int unsigned HoldCycles = 400;
  // Quiet cycles after the last reply, enough to catch a stray extra result.
  localparam int unsigned TailCycles = 32;

  // One reply on the master stream.
  typedef struct packed {
    logic [15:0] word;   // data_out
    logic        wen;    // write_enabled
  } reply_t;

  // One row of the directed table. Rows with pinned set carry a hand-typed reply.
  typedef struct {
    logic        present;
    logic [15:0] cmd;
    logic [15:0] din;
    bit          pinned;
    logic [15:0] want;
    logic        want_we;
  } drill_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT inputs (all known from time 0)
  // --------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_data_i    = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic [31:0] s_axis_tdata  = '0;   // [15:0] command_word, [31:16] data_in
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [23:0] m_axis_tdata;         // [15:0] data_out, [16] write_enabled

  always #1 clk_i = ~clk_i;

  microwire_eeprom_command_executor #(
    .STORE_WORDS(StoreWords)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        stall_go      = 1'b0;   // asks the receiver for one long hold-off

  // Hand-typed reply travelling with the transaction currently offered.
  bit          pin_on   = 1'b0;
  logic [15:0] pin_word = '0;
  logic        pin_we   = 1'b0;

  reply_t      replies_due [$];
  drill_t      drills [$];
  int unsigned mismatches = 0;
  int unsigned kind_tally [1 << $bits(mwece_pkg::kind_e)];

  // Local copy of the device: store image, write-enable flag, config register.
  logic [15:0] eeprom_image [StoreWords];
  logic        model_wen     = 1'b0;
  logic        model_present = 1'b1;

  // --------------------------------------------------------------------------
  // Model of the executor
  // --------------------------------------------------------------------------
  function automatic void fill_image(input int unsigned count, input logic [15:0] v);
    for (int unsigned k = 0; k < count && k < StoreWords; k++) eeprom_image[k] = v;
  endfunction

  // Applies one command to the image and returns what kind of command it was.
  function automatic mwece_pkg::kind_e execute_command(input logic [15:0] cmd,
                                                       input logic [15:0] din,
                                                       output reply_t r);
    int               s;
    int unsigned      span;
    int unsigned      slot;
    logic [1:0]       op;
    mwece_pkg::kind_e k;
    r.word = din;
    k = mwece_pkg::K_PASS;
    if (model_present && cmd != '0) begin
      s = 15;
      while (!cmd[s]) s--;
      r.word = '0;
      k = mwece_pkg::K_ZERO;
      if (s < 4) begin
        // too short to carry opcode and sub-command: treated as write disable
        model_wen = 1'b0;
      end else begin
        op   = cmd[s-1 -: 2];
        span = 1 << (s - 2);
        slot = (cmd & (span - 1)) % StoreWords;   // address wraps to store depth
        case (op)
          mwece_pkg::OpExt: begin
            case (cmd[s-3 -: 2])
              mwece_pkg::SubWrDis: model_wen = 1'b0;
              mwece_pkg::SubWrAll: begin
                // no enable check; covers every address the field can name
                fill_image(span, din);
                k = mwece_pkg::K_FILL;
              end
              mwece_pkg::SubErAll: begin
                if (model_wen) fill_image(StoreWords, mwece_pkg::ErasedWord);
                k = mwece_pkg::K_FILL;
              end
              mwece_pkg::SubWrEn: model_wen = 1'b1;
            endcase
          end
          mwece_pkg::OpWrite: begin
            if (model_wen) eeprom_image[slot] = din;
            k = mwece_pkg::K_WRITE;
          end
          mwece_pkg::OpRead: begin
            r.word = eeprom_image[slot];
            k = mwece_pkg::K_READ;
          end
          mwece_pkg::OpErase: begin
            if (model_wen) eeprom_image[slot] = mwece_pkg::ErasedWord;
            k = mwece_pkg::K_ERASE;
          end
        endcase
      end
    end
    r.wen = model_wen;
    return k;
  endfunction

  // --------------------------------------------------------------------------
  // Command builders
  // --------------------------------------------------------------------------
  // Start bit at s, opcode below it, address field in the s-2 bits below that.
  function automatic logic [15:0] cmd_word(input int unsigned s, input logic [1:0] op,
                                           input logic [15:0] field);
    logic [15:0] mask;
    mask = 16'((1 << (s - 2)) - 1);
    return 16'(1 << s) | (16'(op) << (s - 2)) | (field & mask);
  endfunction

  // Extended opcode: sub-command in the top two address bits.
  function automatic logic [15:0] ext_word(input int unsigned s, input logic [1:0] sub);
    return cmd_word(s, mwece_pkg::OpExt, 16'(sub) << (s - 4));
  endfunction

  // Random command, biased toward well-formed ones that hit a few low addresses
  // so reads see earlier writes. Slow bulk fills are kept rare.
  function automatic logic [15:0] pick_command();
    int unsigned s;
    int unsigned roll;
    logic [15:0] addr;
    logic [1:0]  op;
    logic [1:0]  sub;
    roll = $urandom_range(0, 99);
    if (roll < 3) return '0;                      // no start bit
    if (roll < 10) begin                          // start bit below position 4
      s = $urandom_range(0, 3);
      return 16'((1 << s) | ($urandom & ((1 << s) - 1)));
    end
    s = $urandom_range(4, 15);
    addr = 16'($urandom);
    // hot spot at words 0..7, upper bits kept so wrap still gets exercised
    if ($urandom_range(0, 1) == 1) addr = (addr & ~16'h03FF) | 16'($urandom_range(0, 7));
    roll = $urandom_range(0, 99);
    if (roll < 30)      op = mwece_pkg::OpWrite;
    else if (roll < 55) op = mwece_pkg::OpRead;
    else if (roll < 65) op = mwece_pkg::OpErase;
    else                op = mwece_pkg::OpExt;
    if (op == mwece_pkg::OpExt) begin
      roll = $urandom_range(0, 99);
      if (roll < 45)      sub = mwece_pkg::SubWrEn;
      else if (roll < 65) sub = mwece_pkg::SubWrDis;
      else if (roll < 85) sub = mwece_pkg::SubWrAll;
      else                sub = mwece_pkg::SubErAll;
      if (((sub == mwece_pkg::SubWrAll && s > 9) || sub == mwece_pkg::SubErAll) &&
          $urandom_range(0, 7) != 0)
        op = mwece_pkg::OpRead;
      else
        addr = (addr & ~(16'h3 << (s - 4))) | (16'(sub) << (s - 4));
    end
    return cmd_word(s, op, addr);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus tasks (all but add_drill called at a rising edge, return at a rising edge)
  // --------------------------------------------------------------------------
  task automatic add_drill(input logic present, input logic [15:0] cmd, input logic [15:0] din,
                           input bit pinned, input logic [15:0] want, input logic want_we);
    drill_t row;
    row = '{present, cmd, din, pinned, want, want_we};
    drills.push_back(row);
  endtask

  // Offers one transaction, after a random gap, and returns at its accepting edge.
  // tvalid stays high afterwards so back-to-back items need only one assignment.
  task automatic send_command(input logic [15:0] cmd, input logic [15:0] din, input bit pinned,
                              input logic [15:0] want, input logic want_we);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {din, cmd};
    pin_on        <= pinned;
    pin_word      <= want;
    pin_we        <= want_we;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_command(pick_command(), 16'($urandom), 1'b0, '0, 1'b0);
  endtask

  // Stop offering and wait until every reply is in. One edge first, so the
  // scoreboard has logged the last accepted command.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_present(input logic v);
    cfg_data_i <= v;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random tready, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_go && !held) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        held = 1'b1;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Scoreboard: config tracking, prediction at input, checking at output
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    reply_t           due;
    mwece_pkg::kind_e k;
    if (rst_ni) begin
      if (cfg_we_i) model_present = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        k = execute_command(s_axis_tdata[15:0], s_axis_tdata[31:16], due);
        if (pin_on) due = '{word: pin_word, wen: pin_we};
        kind_tally[k]++;
        replies_due.push_back(due);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (replies_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, expected none, got %h", $time,
                   m_axis_tdata);
        end else begin
          due = replies_due.pop_front();
          if (m_axis_tdata[15:0] !== due.word) begin
            mismatches++;
            $display("%0t: data_out mismatch, expected %h, got %h", $time, due.word,
                     m_axis_tdata[15:0]);
          end
          if (m_axis_tdata[16] !== due.wen) begin
            mismatches++;
            $display("%0t: write_enabled mismatch, expected %b, got %b", $time, due.wen,
                     m_axis_tdata[16]);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    logic present_now;
    present_now = 1'b1;
    foreach (eeprom_image[i]) eeprom_image[i] = mwece_pkg::ErasedWord;

    // Directed table: erased store, enable gating, short and empty commands,
    // address wrap, bulk fills at both ends of the field width, device absent.
    add_drill(1, cmd_word(8, mwece_pkg::OpRead, 0),          16'h0000, 1, 16'hFFFF, 0);
    // not enabled
    add_drill(1, cmd_word(8, mwece_pkg::OpWrite, 5),         16'h1234, 1, 16'h0000, 0);
    add_drill(1, cmd_word(8, mwece_pkg::OpRead, 5),          16'h0000, 1, 16'hFFFF, 0);
    add_drill(1, ext_word(8, mwece_pkg::SubWrEn),            16'h0000, 1, 16'h0000, 1);
    add_drill(1, cmd_word(8, mwece_pkg::OpWrite, 5),         16'hA5A5, 1, 16'h0000, 1);
    add_drill(1, cmd_word(8, mwece_pkg::OpRead, 5),          16'h0000, 1, 16'hA5A5, 1);
    // no start bit
    add_drill(1, 16'h0000,                                   16'hFFFF, 1, 16'hFFFF, 1);
    // start bit at 3
    add_drill(1, 16'h000F,                                   16'h0000, 1, 16'h0000, 0);
    add_drill(1, cmd_word(8, mwece_pkg::OpRead, 5),          16'h0000, 1, 16'hA5A5, 0);
    add_drill(1, ext_word(8, mwece_pkg::SubWrEn),            16'h0000, 1, 16'h0000, 1);
    add_drill(1, cmd_word(8, mwece_pkg::OpErase, 5),         16'h0000, 1, 16'h0000, 1);
    add_drill(1, cmd_word(8, mwece_pkg::OpRead, 5),          16'h0000, 1, 16'hFFFF, 1);
    // wraps to 3FF
    add_drill(1, cmd_word(15, mwece_pkg::OpWrite, 16'h1FFF), 16'h0000, 1, 16'h0000, 1);
    add_drill(1, cmd_word(12, mwece_pkg::OpRead, 16'h03FF),  16'h0000, 1, 16'h0000, 1);
    // words 0..3
    add_drill(1, ext_word(4, mwece_pkg::SubWrAll),           16'h5A5A, 1, 16'h0000, 1);
    add_drill(1, cmd_word(15, mwece_pkg::OpRead, 3),         16'h0000, 1, 16'h5A5A, 1);
    add_drill(1, 16'hFFFF,                                   16'hFFFF, 0, 16'h0000, 0);
    add_drill(1, ext_word(15, mwece_pkg::SubErAll),          16'h0000, 1, 16'h0000, 1);
    add_drill(1, cmd_word(15, mwece_pkg::OpRead, 3),         16'h0000, 1, 16'hFFFF, 1);
    // capped at depth
    add_drill(1, ext_word(15, mwece_pkg::SubWrAll),          16'h0F0F, 0, 16'h0000, 0);
    add_drill(1, cmd_word(15, mwece_pkg::OpRead, 16'h03FF),  16'h0000, 1, 16'h0F0F, 1);
    add_drill(1, ext_word(15, mwece_pkg::SubWrDis),          16'h0000, 1, 16'h0000, 0);
    // pass-through
    add_drill(0, cmd_word(15, mwece_pkg::OpRead, 3),         16'h1357, 1, 16'h1357, 0);
    add_drill(0, ext_word(15, mwece_pkg::SubWrEn),           16'hBEEF, 1, 16'hBEEF, 0);
    add_drill(1, cmd_word(15, mwece_pkg::OpRead, 3),         16'h0000, 1, 16'h0F0F, 0);

    repeat (6) @(posedge clk_i);
    rst_ni        <= 1'b1;
    send_idle_pct <= 14;
    recv_idle_pct <= 83;

    foreach (drills[i]) begin
      if (drills[i].present !== present_now) begin
        settle();
        write_present(drills[i].present);
        present_now = drills[i].present;
      end
      send_command(drills[i].cmd, drills[i].din, drills[i].pinned, drills[i].want,
                   drills[i].want_we);
    end
    settle();

    // Random traffic, slow receiver.
    send_random(550);
    settle();

    // Slow sender; a short stretch with the device detached.
    send_idle_pct <= 83;
    recv_idle_pct <= 14;
    write_present(1'b0);
    send_random(60);
    settle();
    write_present(1'b1);
    send_random(500);
    settle();

    // Full rate, opening with a long receiver hold-off to fill the pipe.
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    stall_go      <= 1'b1;
    send_random(490);
    settle();
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d reads, %0d writes, %0d erases, %0d bulk fills, %0d enable/disable",
             kind_tally[mwece_pkg::K_READ], kind_tally[mwece_pkg::K_WRITE],
             kind_tally[mwece_pkg::K_ERASE], kind_tally[mwece_pkg::K_FILL],
             kind_tally[mwece_pkg::K_ZERO]);
    $display("and %0d pass-throughs, over both device_present settings and three stall mixes",
             kind_tally[mwece_pkg::K_PASS]);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #TimeoutUnits;
    $display("%0t: timeout, %0d replies still outstanding", $time, replies_due.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
src/mwece_pkg.sv
src/microwire_eeprom_command_executor.sv
verif/microwire_eeprom_command_executor_tb.sv
